// ===== rtl/core/cbm_pkg.sv =====
`timescale 1ns / 1ps

package cbm_pkg;

    // Access kinds carried in s_tuser
    typedef enum logic [1:0] {
        KIND_CPU_WRITE = 2'd0,
        KIND_CPU_READ  = 2'd1,
        KIND_PPU       = 2'd2,
        KIND_NONE      = 2'd3
    } kind_t;

    // Configuration register indexes
    localparam logic [7:0] CFG_PRG_MASK = 8'd0;
    localparam logic [7:0] CFG_CHR_MASK = 8'd1;

    // Register addresses and range starts in the CPU space
    localparam logic [15:0] ADDR_EXT_MODE  = 16'h5000;
    localparam logic [15:0] ADDR_LOW_START = 16'h5000;
    localparam logic [15:0] ADDR_HIGH      = 16'h8000;
    localparam logic [15:0] ADDR_SELECT    = 16'h8000;
    localparam logic [15:0] ADDR_LOAD      = 16'h8001;
    localparam logic [15:0] ADDR_QUIRK     = 16'h8003;
    localparam logic [15:0] ADDR_MIRROR    = 16'hA000;
    localparam logic [15:0] ADDR_IRQ_LATCH = 16'hC000;
    localparam logic [15:0] ADDR_IRQ_RLD   = 16'hC001;
    localparam logic [15:0] ADDR_IRQ_OFF   = 16'hE000;
    localparam logic [15:0] ADDR_IRQ_ON    = 16'hE001;

    // Protection and quirk bytes
    localparam logic [7:0] QUIRK_ARM     = 8'h28;
    localparam logic [7:0] QUIRK_ALT     = 8'h2A;
    localparam logic [7:0] QUIRK_BANK    = 8'h17;
    localparam logic [7:0] PROT_BYTE_LO  = 8'h80;
    localparam logic [7:0] PROT_BYTE_MID = 8'h42;
    localparam logic [7:0] PROT_BYTE_HI  = 8'h00;
    localparam logic [7:0] FIXED_BANK_C  = 8'hFE;
    localparam logic [7:0] FIXED_BANK_E  = 8'hFF;

    // Scanline counter: rising A13 transitions counted for one tick
    localparam logic [5:0] EDGES_PER_LINE = 6'd42;

    // Packed result word, highest field first
    typedef struct packed {
        logic [3:0] pad;
        logic       irq_line;
        logic       mirror_select;
        logic [8:0] chr_bank;
        logic [7:0] prg_bank;
        logic       read_driven;
        logic [7:0] read_data;
    } result_t;

endpackage

// ===== rtl/core/cartridge_bank_mapper_irq_unit.sv =====
`timescale 1ns / 1ps

// Cartridge bank mapper with scanline IRQ.
//
// Request channel (s_*): one bus access per request. s_tuser carries the
// access kind (CPU write, CPU read, PPU access); s_tdata carries address
// and write byte. Result channel (m_*): one result per request with the
// read/protection byte, the translated PRG and CHR banks, mirroring and
// the IRQ line as they stand after the access.
// Configuration channel (cfg_*): index 0 writes the PRG bank mask, index 1
// the CHR bank mask; other indexes are dropped. Always ready.
//
// The result is registered: it is valid in the cycle after the request is
// accepted. Throughput is one request per cycle while results are taken;
// all decode, translation and counter update happen in one pass between
// the request handshake and the result register.
// Reset (aresetn low, synchronous) clears all mapper state, sets both masks
// to all ones and empties the result register. While the receiver stalls
// with a result held, s_tready stays low; it returns high in the cycle the
// held result is taken.
module cartridge_bank_mapper_irq_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [15:0] address, [23:16] data
    input  logic [1:0]  s_tuser,    // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data, [8] read_driven, [16:9] prg_bank, [25:17] chr_bank,
    // [26] mirror_select, [27] irq_line, [31:28] zero
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [8:0]  cfg_data
);
    import cbm_pkg::*;

    // Configuration and mapper state
    logic [7:0] prg_mask_reg;
    logic [8:0] chr_mask_reg;
    logic [7:0] bank_regs_reg [8];
    logic [7:0] ext_mode_reg, command_reg, quirk_value_reg, last_written_reg;
    logic [7:0] irq_reload_reg;
    logic [9:0] irq_counter_reg;
    logic       write_armed_reg, c000_override_reg, irq_enable_reg;
    logic       irq_pending_reg, mirror_bit_reg, prev_a13_reg;
    logic [5:0] edge_count_reg;
    logic       out_valid_reg;
    result_t    out_reg;

    logic [7:0] bank_regs_next [8];
    logic [7:0] ext_mode_next, command_next, quirk_value_next, last_written_next;
    logic [7:0] irq_reload_next;
    logic [9:0] irq_counter_next;
    logic       write_armed_next, c000_override_next, irq_enable_next;
    logic       irq_pending_next, mirror_bit_next, prev_a13_next;
    logic [5:0] edge_count_next;
    result_t    out_next;

    kind_t       kind;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        accept;

    assign kind      = kind_t'(s_tuser);
    assign addr      = s_tdata[15:0];
    assign wdata     = s_tdata[23:16];
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    // PRG translation
    logic [1:0] slot;
    logic [7:0] prg_raw;
    assign slot = addr[14:13];
    always_comb begin
        if (slot == 2'd2 && c000_override_reg) begin
            prg_raw = QUIRK_BANK;
        end else if (ext_mode_reg[7]) begin
            if (ext_mode_reg[5]) begin
                prg_raw = {2'b00, ext_mode_reg[4:1], slot};
            end else begin
                prg_raw = {2'b00, ext_mode_reg[4:0], slot[0]};
            end
        end else begin
            case (slot)
                2'd0:    prg_raw = bank_regs_reg[6];
                2'd1:    prg_raw = bank_regs_reg[7];
                2'd2:    prg_raw = FIXED_BANK_C;
                default: prg_raw = FIXED_BANK_E;
            endcase
        end
    end

    // CHR translation; A12 swapped by command bit 7
    logic [12:0] ca;
    logic [2:0]  chr_idx;
    logic [7:0]  chr_reg_val;
    logic [8:0]  chr_raw;
    assign ca          = {addr[12] ^ command_reg[7], addr[11:0]};
    assign chr_idx     = ca[12] ? 3'(3'd2 + {1'b0, ca[11:10]}) : {2'b00, ca[11]};
    assign chr_reg_val = bank_regs_reg[chr_idx];
    assign chr_raw     = ca[12] ? {1'b0, chr_reg_val}
                                : {1'b1, chr_reg_val[7:1], ca[10]};

    // Protection byte
    logic [7:0] prot_byte;
    always_comb begin
        case (last_written_reg[1:0])
            2'd0, 2'd1: prot_byte = PROT_BYTE_LO;
            2'd2:       prot_byte = PROT_BYTE_MID;
            default:    prot_byte = PROT_BYTE_HI;
        endcase
    end

    // Next state and result for the current request
    logic       a13;
    logic [5:0] edge_inc;
    logic [9:0] counter_dec;
    always_comb begin
        bank_regs_next     = bank_regs_reg;
        ext_mode_next      = ext_mode_reg;
        command_next       = command_reg;
        quirk_value_next   = quirk_value_reg;
        last_written_next  = last_written_reg;
        irq_reload_next    = irq_reload_reg;
        irq_counter_next   = irq_counter_reg;
        write_armed_next   = write_armed_reg;
        c000_override_next = c000_override_reg;
        irq_enable_next    = irq_enable_reg;
        irq_pending_next   = irq_pending_reg;
        mirror_bit_next    = mirror_bit_reg;
        prev_a13_next      = prev_a13_reg;
        edge_count_next    = edge_count_reg;
        out_next           = '0;
        a13                = addr[13];
        edge_inc           = 6'(edge_count_reg + 6'd1);
        counter_dec        = 10'(irq_counter_reg - 10'd1);

        case (kind)
            KIND_CPU_WRITE: begin
                if (addr >= ADDR_HIGH) begin
                    last_written_next = wdata;
                    if (addr == ADDR_QUIRK) begin
                        if (wdata == QUIRK_ARM || wdata == QUIRK_ALT) begin
                            quirk_value_next = wdata;
                        end
                    end else if (addr == ADDR_SELECT) begin
                        quirk_value_next = '0;
                    end
                    case (addr)
                        ADDR_IRQ_LATCH: begin
                            irq_reload_next  = wdata;
                            irq_counter_next = {2'b00, wdata};
                        end
                        ADDR_IRQ_RLD: begin
                            irq_counter_next = {2'b00, irq_reload_reg};
                            edge_count_next  = '0;
                            prev_a13_next    = 1'b0;
                        end
                        ADDR_IRQ_OFF: begin
                            irq_enable_next  = 1'b0;
                            irq_pending_next = 1'b0;
                        end
                        ADDR_IRQ_ON: irq_enable_next = 1'b1;
                        ADDR_MIRROR: mirror_bit_next = wdata[0];
                        ADDR_SELECT: begin
                            command_next     = wdata;
                            write_armed_next = 1'b1;
                        end
                        ADDR_LOAD: begin
                            if (write_armed_reg) begin
                                bank_regs_next[command_reg[2:0]] = wdata;
                                c000_override_next = 1'b0;
                                write_armed_next   = 1'b0;
                            end
                            if (quirk_value_reg == QUIRK_ARM) begin
                                c000_override_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end else if (addr >= ADDR_LOW_START) begin
                    last_written_next = wdata;
                    if (addr == ADDR_EXT_MODE) begin
                        ext_mode_next = wdata;
                    end
                    c000_override_next = 1'b0;
                end
            end
            KIND_CPU_READ: begin
                if (addr >= ADDR_HIGH) begin
                    out_next.prg_bank = prg_raw & prg_mask_reg;
                end else if (addr[15:12] == ADDR_EXT_MODE[15:12]) begin
                    out_next.read_driven = 1'b1;
                    out_next.read_data   = prot_byte;
                end
            end
            KIND_PPU: begin
                if (!addr[13]) begin
                    out_next.chr_bank = chr_raw & chr_mask_reg;
                end
                // Scanline tick on every Nth rising edge of A13
                if (a13 && !prev_a13_reg) begin
                    edge_count_next = edge_inc;
                    if (edge_inc == EDGES_PER_LINE) begin
                        edge_count_next = '0;
                        if (irq_enable_reg && !irq_counter_reg[9]) begin
                            irq_counter_next = counter_dec;
                            if (counter_dec[9]) begin
                                irq_pending_next = 1'b1;
                            end
                        end
                    end
                end
                prev_a13_next = a13;
            end
            default: ;
        endcase

        out_next.mirror_select = mirror_bit_next;
        out_next.irq_line      = irq_pending_next;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_mask_reg      <= '1;
            chr_mask_reg      <= '1;
            for (int i = 0; i < 8; i++) begin
                bank_regs_reg[i] <= '0;
            end
            ext_mode_reg      <= '0;
            command_reg       <= '0;
            quirk_value_reg   <= '0;
            last_written_reg  <= '0;
            irq_reload_reg    <= '0;
            irq_counter_reg   <= '0;
            write_armed_reg   <= 1'b0;
            c000_override_reg <= 1'b0;
            irq_enable_reg    <= 1'b0;
            irq_pending_reg   <= 1'b0;
            mirror_bit_reg    <= 1'b0;
            prev_a13_reg      <= 1'b0;
            edge_count_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_PRG_MASK) begin
                    prg_mask_reg <= cfg_data[7:0];
                end else if (cfg_index == CFG_CHR_MASK) begin
                    chr_mask_reg <= cfg_data;
                end
            end
            if (accept) begin
                bank_regs_reg     <= bank_regs_next;
                ext_mode_reg      <= ext_mode_next;
                command_reg       <= command_next;
                quirk_value_reg   <= quirk_value_next;
                last_written_reg  <= last_written_next;
                irq_reload_reg    <= irq_reload_next;
                irq_counter_reg   <= irq_counter_next;
                write_armed_reg   <= write_armed_next;
                c000_override_reg <= c000_override_next;
                irq_enable_reg    <= irq_enable_next;
                irq_pending_reg   <= irq_pending_next;
                mirror_bit_reg    <= mirror_bit_next;
                prev_a13_reg      <= prev_a13_next;
                edge_count_reg    <= edge_count_next;
                out_valid_reg     <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

    // Checks
    a_irq_needs_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(irq_pending_reg) |-> irq_enable_reg)
        else $error("irq pending raised while disabled");

    a_edge_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        edge_count_reg != EDGES_PER_LINE)
        else $error("edge count reached line length");

    a_result_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.read_driven |->
            out_reg.prg_bank == '0 && out_reg.chr_bank == '0)
        else $error("protection read carried a bank");

    a_override_from_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(c000_override_reg) |-> $past(accept && kind == KIND_CPU_WRITE))
        else $error("override set without a cpu write");

endmodule
